// ===== rtl/ppr_pkg.sv =====
// shared types and constants for the predictive pixel residual coder
package ppr_pkg;

  localparam int CFG_DIM_W   = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int BITCOUNT_W  = 30;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_AVG     = 2'd0;
  localparam logic [1:0] MODE_PLANAR  = 2'd1;
  localparam logic [1:0] MODE_MED     = 2'd2;
  localparam logic [1:0] MODE_AVG_ALT = 2'd3;

  localparam logic [7:0] RES_ZERO = 8'd128;

  typedef enum logic [1:0] {
    CLS_FIRST = 2'd0,
    CLS_ROW0  = 2'd1,
    CLS_COL0  = 2'd2,
    CLS_INNER = 2'd3
  } cls_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0]            res_red;
    logic [7:0]            res_green;
    logic [7:0]            res_blue;
    logic                  frame_end;
    logic [BITCOUNT_W-1:0] bit_count;
  } res_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    pix_t cur;
    pix_t ul;
    pix_t up;
    pix_t left;
    cls_t cls;
    logic last;
  } job_t;

endpackage

// ===== rtl/ppr_front.sv =====
// front end: position tracking, line buffer and neighbor context
module ppr_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ppr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  ppr_pkg::pix_t in_data,
  output logic          push,
  output ppr_pkg::job_t push_job,
  input  logic          q_full
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CMP_A = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
  localparam int CMPW  = (CMP_A > ppr_pkg::CFG_DIM_W + 1) ? CMP_A : ppr_pkg::CFG_DIM_W + 1;

  ppr_pkg::pix_t row_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             f_valid_r;
  ppr_pkg::pix_t    f_pix_r;
  ppr_pkg::cls_t    f_cls_r;
  logic             f_last_r;
  ppr_pkg::pix_t    above_r;
  ppr_pkg::pix_t    ul_r;
  ppr_pkg::pix_t    left_r;

  logic            accept;
  logic [CMPW-1:0] w_eff;
  logic [CMPW-1:0] h_eff;
  logic            last_col;
  logic            last_row;
  ppr_pkg::cls_t   cls_nxt;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(cfg.width) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = CMPW'(1);
    end else if (CMPW'(cfg.height) > CMPW'(MAX_HEIGHT)) begin
      h_eff = CMPW'(MAX_HEIGHT);
    end else begin
      h_eff = CMPW'(cfg.height);
    end
  end

  assign last_col = (CMPW'(col_r) + CMPW'(1)) >= w_eff;
  assign last_row = (CMPW'(row_r) + CMPW'(1)) >= h_eff;

  always_comb begin
    priority if (row_r == '0 && col_r == '0) begin
      cls_nxt = ppr_pkg::CLS_FIRST;
    end else if (row_r == '0) begin
      cls_nxt = ppr_pkg::CLS_ROW0;
    end else if (col_r == '0) begin
      cls_nxt = ppr_pkg::CLS_COL0;
    end else begin
      cls_nxt = ppr_pkg::CLS_INNER;
    end
  end

  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid_r && !q_full;

  assign push_job.cur  = f_pix_r;
  assign push_job.ul   = ul_r;
  assign push_job.up   = above_r;
  assign push_job.left = left_r;
  assign push_job.cls  = f_cls_r;
  assign push_job.last = f_last_r;

  // line buffer: read old entry, write current pixel at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      above_r        <= row_mem[col_r];
      row_mem[col_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_pix_r  <= in_data;
      f_cls_r  <= cls_nxt;
      f_last_r <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      f_valid_r <= 1'b0;
      ul_r      <= '0;
      left_r    <= '0;
    end else begin
      if (accept) begin
        f_valid_r <= 1'b1;
        if (last_col && last_row) begin
          col_r <= '0;
          row_r <= '0;
        end else if (last_col) begin
          col_r <= '0;
          row_r <= ROW_W'(row_r + 1'b1);
        end else begin
          col_r <= COL_W'(col_r + 1'b1);
        end
      end else if (push) begin
        f_valid_r <= 1'b0;
      end
      if (push) begin
        ul_r   <= above_r;
        left_r <= f_pix_r;
      end
    end
  end

endmodule

// ===== rtl/ppr_queue.sv =====
// short job queue between front and back end
module ppr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output ppr_pkg::job_t head
);

  localparam int DEPTH = ppr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  ppr_pkg::job_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full    = count_r == (PTR_W+1)'(DEPTH);
  assign q_valid = count_r != '0;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ppr_back.sv =====
// back end: residuals, run tracking and bitstream size
module ppr_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    mode,
  input  logic          q_valid,
  input  ppr_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output ppr_pkg::res_t out_data
);

  localparam int RUN_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int LB_W  = $clog2(RUN_W + 1);
  localparam int FAC_W = $clog2(24 + RUN_W + 1);
  localparam int PRD_W = RUN_W + FAC_W + 1;

  function automatic logic [7:0] resid(logic [7:0] p, logic [7:0] a, logic [7:0] b,
                                       logic [7:0] c, ppr_pkg::cls_t cls,
                                       logic [1:0] md);
    logic signed [10:0] sa;
    logic signed [10:0] sb;
    logic signed [10:0] sc;
    logic signed [10:0] lo;
    logic signed [10:0] hi;
    logic signed [10:0] pred;
    logic signed [10:0] r;
    logic [7:0]         res;
    sa = $signed({3'b000, a});
    sb = $signed({3'b000, b});
    sc = $signed({3'b000, c});
    lo = (sb < sc) ? sb : sc;
    hi = (sb < sc) ? sc : sb;
    unique case (md)
      ppr_pkg::MODE_PLANAR: pred = sb + sc - sa;
      ppr_pkg::MODE_MED: begin
        priority if (sa >= hi) begin
          pred = lo;
        end else if (sa <= lo) begin
          pred = hi;
        end else begin
          pred = sb + sc - sa;
        end
      end
      ppr_pkg::MODE_AVG,
      ppr_pkg::MODE_AVG_ALT: pred = (sb + sc) >>> 1;
    endcase
    unique case (cls)
      ppr_pkg::CLS_ROW0:  pred = sc;
      ppr_pkg::CLS_COL0:  pred = sb;
      ppr_pkg::CLS_FIRST,
      ppr_pkg::CLS_INNER: pred = pred;
    endcase
    r = $signed({3'b000, p}) - pred + 11'sd128;
    priority if (r < 11'sd0) begin
      res = 8'd0;
    end else if (r > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = r[7:0];
    end
    if (cls == ppr_pkg::CLS_FIRST) begin
      res = p;
    end
    return res;
  endfunction

  logic adv;

  // stage 1: residuals
  logic          s1_valid_r;
  ppr_pkg::pix_t s1_res_r;
  logic          s1_flat_r;
  logic          s1_first_r;
  logic          s1_last_r;
  ppr_pkg::pix_t res_nxt;

  // stage 2: run counters
  logic             s2_valid_r;
  ppr_pkg::pix_t    s2_res_r;
  logic             s2_last_r;
  logic [RUN_W-1:0] s2_longest_r;
  logic [RUN_W-1:0] s2_tokens_r;

  // stage 3: length bits
  logic             s3_valid_r;
  ppr_pkg::pix_t    s3_res_r;
  logic             s3_last_r;
  logic [RUN_W-1:0] s3_tokens_r;
  logic [LB_W-1:0]  s3_lbits_r;

  logic             o_valid_r;
  ppr_pkg::res_t    o_data_r;

  logic [RUN_W-1:0] cur_run_r;
  logic [RUN_W-1:0] longest_r;
  logic [RUN_W-1:0] token_run_r;
  logic [RUN_W-1:0] token_cnt_r;
  logic [RUN_W-1:0] cur_run_nxt;
  logic [RUN_W-1:0] longest_nxt;
  logic [RUN_W-1:0] token_run_nxt;
  logic [RUN_W-1:0] token_cnt_nxt;
  logic [RUN_W-1:0] longest_fin;
  logic [RUN_W-1:0] tokens_fin;

  logic [RUN_W-1:0] lb_vec;
  logic [LB_W-1:0]  lbits_nxt;
  logic [FAC_W-1:0] factor;
  logic [PRD_W-1:0] product;

  assign adv       = !o_valid_r || !out_stall;
  assign pop       = adv && q_valid;
  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  assign res_nxt.red   = resid(head.cur.red, head.ul.red, head.up.red, head.left.red,
                               head.cls, mode);
  assign res_nxt.green = resid(head.cur.green, head.ul.green, head.up.green,
                               head.left.green, head.cls, mode);
  assign res_nxt.blue  = resid(head.cur.blue, head.ul.blue, head.up.blue, head.left.blue,
                               head.cls, mode);

  always_comb begin
    cur_run_nxt   = cur_run_r;
    longest_nxt   = longest_r;
    token_run_nxt = token_run_r;
    token_cnt_nxt = token_cnt_r;
    if (s1_flat_r) begin
      cur_run_nxt = RUN_W'(cur_run_r + 1'b1);
    end else begin
      if (cur_run_r > longest_r) begin
        longest_nxt = cur_run_r;
      end
      cur_run_nxt = '0;
    end
    if (!s1_first_r) begin
      if (s1_flat_r) begin
        token_run_nxt = RUN_W'(token_run_r + 1'b1);
      end else begin
        token_cnt_nxt = RUN_W'(token_cnt_r + 1'b1);
        token_run_nxt = '0;
      end
    end
    longest_fin = (cur_run_nxt > longest_nxt) ? cur_run_nxt : longest_nxt;
    tokens_fin  = RUN_W'(token_cnt_nxt + RUN_W'(token_run_nxt != '0));
  end

  // ceil log2 of the longest run, zero for runs of zero or one
  always_comb begin
    lb_vec    = RUN_W'(s2_longest_r - 1'b1);
    lbits_nxt = '0;
    for (int i = 0; i < RUN_W; i++) begin
      if (lb_vec[i]) begin
        lbits_nxt = LB_W'(i + 1);
      end
    end
    if (s2_longest_r <= RUN_W'(1)) begin
      lbits_nxt = '0;
    end
  end

  assign factor  = FAC_W'(24) + FAC_W'(s3_lbits_r);
  assign product = PRD_W'(s3_tokens_r) * PRD_W'(factor) + PRD_W'(6);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_res_r   <= res_nxt;
      s1_flat_r  <= res_nxt.red == ppr_pkg::RES_ZERO && res_nxt.green == ppr_pkg::RES_ZERO
                    && res_nxt.blue == ppr_pkg::RES_ZERO;
      s1_first_r <= head.cls == ppr_pkg::CLS_FIRST;
      s1_last_r  <= head.last;

      s2_res_r     <= s1_res_r;
      s2_last_r    <= s1_last_r;
      s2_longest_r <= longest_fin;
      s2_tokens_r  <= tokens_fin;

      s3_res_r    <= s2_res_r;
      s3_last_r   <= s2_last_r;
      s3_tokens_r <= s2_tokens_r;
      s3_lbits_r  <= lbits_nxt;

      o_data_r.res_red   <= s3_res_r.red;
      o_data_r.res_green <= s3_res_r.green;
      o_data_r.res_blue  <= s3_res_r.blue;
      o_data_r.frame_end <= s3_last_r;
      o_data_r.bit_count <= s3_last_r ? ppr_pkg::BITCOUNT_W'(product) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      o_valid_r   <= 1'b0;
      cur_run_r   <= '0;
      longest_r   <= '0;
      token_run_r <= '0;
      token_cnt_r <= '0;
    end else if (adv) begin
      s1_valid_r <= q_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      o_valid_r  <= s3_valid_r;
      if (s1_valid_r) begin
        if (s1_last_r) begin
          cur_run_r   <= '0;
          longest_r   <= '0;
          token_run_r <= '0;
          token_cnt_r <= '0;
        end else begin
          cur_run_r   <= cur_run_nxt;
          longest_r   <= longest_nxt;
          token_run_r <= token_run_nxt;
          token_cnt_r <= token_cnt_nxt;
        end
      end
    end
  end

endmodule

// ===== rtl/predictive_pixel_residual_rle_size_top.sv =====
// top level of the predictive pixel residual coder with run-length size count
// an accepted input beat passes the front register, the job queue, back-end stages 1 to 3 and the output register
// throughput: one pixel per cycle while in_stall is low, set by the single line buffer read and write per pixel
// a four-entry job queue lets the front end keep accepting while the output is stalled, until the queue fills
// reset: synchronous active-low rst_n clears position, neighbors and run counters and sets config to mode AVG, 1x1
// the line buffer is not cleared; stale entries read in row 0 of a frame are not used by the prediction
module predictive_pixel_residual_rle_size_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ppr_pkg::pix_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ppr_pkg::res_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppr_pkg::CFG_DIM_W-1:0]   cfg_data
);

  ppr_pkg::cfg_t cfg_r;
  logic          push;
  ppr_pkg::job_t push_job;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  ppr_pkg::job_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= ppr_pkg::MODE_AVG;
      cfg_r.width  <= ppr_pkg::CFG_DIM_W'(1);
      cfg_r.height <= ppr_pkg::CFG_DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ppr_pkg::CFG_MODE:   cfg_r.mode   <= cfg_data[1:0];
        ppr_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_data;
        ppr_pkg::CFG_HEIGHT: cfg_r.height <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  ppr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  ppr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  ppr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (cfg_r.mode),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_predictive_pixel_residual_rle_size_top.sv =====
// testbench for the predictive pixel residual coder with run-length size count
module tb_predictive_pixel_residual_rle_size_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX      = 4096;
  localparam int unsigned ROWS_MAX      = 4096;
  localparam int unsigned RANDOM_PIXELS = 560;
  localparam int unsigned QUIET_TAIL    = 120;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam logic [ppr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  class residual_tracker;
    logic [1:0]                    mode_reg;
    logic [ppr_pkg::CFG_DIM_W-1:0] width_reg;
    logic [ppr_pkg::CFG_DIM_W-1:0] height_reg;
    ppr_pkg::pix_t                 line_buf [LINE_MAX];
    ppr_pkg::pix_t                 left_px;
    ppr_pkg::pix_t                 upleft_px;
    int unsigned                   col_idx;
    int unsigned                   row_idx;
    int unsigned                   run_now;
    int unsigned                   run_best;
    int unsigned                   run_tail;
    int unsigned                   token_total;
    ppr_pkg::res_t                 expected_res [$];
    int unsigned                   beats_seen;
    int unsigned                   mismatches;

    function new();
      mode_reg    = ppr_pkg::MODE_AVG;
      width_reg   = 1;
      height_reg  = 1;
      foreach (line_buf[i]) line_buf[i] = '0;
      left_px     = '0;
      upleft_px   = '0;
      col_idx     = 0;
      row_idx     = 0;
      run_now     = 0;
      run_best    = 0;
      run_tail    = 0;
      token_total = 0;
      beats_seen  = 0;
      mismatches  = 0;
    endfunction

    static function int unsigned dim_limit(logic [ppr_pkg::CFG_DIM_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void write_register(logic [ppr_pkg::CFG_IDX_W-1:0] idx,
                                 logic [ppr_pkg::CFG_DIM_W-1:0] val);
      case (idx)
        ppr_pkg::CFG_MODE:   mode_reg = val[1:0];
        ppr_pkg::CFG_WIDTH:  width_reg = val;
        ppr_pkg::CFG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int channel(ppr_pkg::pix_t x, int k);
      case (k)
        0:       return int'(x.red);
        1:       return int'(x.green);
        default: return int'(x.blue);
      endcase
    endfunction

    function logic [7:0] clamp_res(int p, int pred);
      int r;
      r = p - pred + 128;
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return 8'(r);
    endfunction

    function int predict(int a, int b, int c);
      int lo, hi;
      lo = (b < c) ? b : c;
      hi = (b < c) ? c : b;
      if (mode_reg == ppr_pkg::MODE_PLANAR) return b + c - a;
      if (mode_reg == ppr_pkg::MODE_MED) begin
        if (a >= hi) return lo;
        if (a <= lo) return hi;
        return b + c - a;
      end
      return (b + c) / 2;
    endfunction

    function void note_pixel(ppr_pkg::pix_t px);
      int unsigned     w, h, lbits, best;
      longint unsigned tokens, bits;
      ppr_pkg::pix_t   above;
      int              p, a, b, c, k;
      logic [7:0]      res [3];
      bit              first, flat, last_col, frame_done;
      ppr_pkg::res_t   want;
      w = dim_limit(width_reg, LINE_MAX);
      h = dim_limit(height_reg, ROWS_MAX);
      above = line_buf[col_idx];
      first = (row_idx == 0) && (col_idx == 0);
      for (k = 0; k < 3; k++) begin
        p = channel(px, k);
        a = channel(upleft_px, k);
        b = channel(above, k);
        c = channel(left_px, k);
        if (first) res[k] = 8'(p);
        else if (row_idx == 0) res[k] = clamp_res(p, c);
        else if (col_idx == 0) res[k] = clamp_res(p, b);
        else res[k] = clamp_res(p, predict(a, b, c));
      end
      flat = (res[0] == ppr_pkg::RES_ZERO) && (res[1] == ppr_pkg::RES_ZERO)
             && (res[2] == ppr_pkg::RES_ZERO);
      if (flat) begin
        run_now++;
      end else begin
        if (run_now > run_best) run_best = run_now;
        run_now = 0;
      end
      if (!first) begin
        if (flat) begin
          run_tail++;
        end else begin
          token_total++;
          run_tail = 0;
        end
      end
      line_buf[col_idx] = px;
      upleft_px = above;
      left_px = px;
      last_col = (col_idx + 1 >= w);
      frame_done = last_col && (row_idx + 1 >= h);
      want = '0;
      want.res_red   = res[0];
      want.res_green = res[1];
      want.res_blue  = res[2];
      want.frame_end = frame_done;
      if (frame_done) begin
        best = (run_now > run_best) ? run_now : run_best;
        tokens = longint'(token_total) + ((run_tail != 0) ? 1 : 0);
        lbits = 0;
        while (lbits < 40 && (64'd1 << lbits) < best) lbits++;
        bits = 6 + tokens * (24 + lbits);
        want.bit_count = ppr_pkg::BITCOUNT_W'(bits);
        col_idx = 0;
        row_idx = 0;
        run_now = 0;
        run_best = 0;
        run_tail = 0;
        token_total = 0;
      end else if (last_col) begin
        col_idx = 0;
        row_idx++;
      end else begin
        col_idx++;
      end
      expected_res.insert(expected_res.size(), want);
    endfunction

    task report(string msg);
      mismatches++;
      $display("ERROR: beat %0d: %s", beats_seen, msg);
    endtask

    task check_output(ppr_pkg::res_t got);
      ppr_pkg::res_t want;
      beats_seen++;
      if (expected_res.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_res.pop_front();
      if (got.res_red !== want.res_red)
        report($sformatf("res_red got %0d want %0d", got.res_red, want.res_red));
      if (got.res_green !== want.res_green)
        report($sformatf("res_green got %0d want %0d", got.res_green, want.res_green));
      if (got.res_blue !== want.res_blue)
        report($sformatf("res_blue got %0d want %0d", got.res_blue, want.res_blue));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end got %0b want %0b", got.frame_end, want.frame_end));
      if (got.bit_count !== want.bit_count)
        report($sformatf("bit_count got %0d want %0d", got.bit_count, want.bit_count));
    endtask

    task close();
      while (expected_res.size() != 0) begin
        void'(expected_res.pop_front());
        report("expected result never arrived");
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  ppr_pkg::pix_t                 in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ppr_pkg::res_t                 out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ppr_pkg::CFG_IDX_W-1:0] cfg_index = ppr_pkg::CFG_MODE;
  logic [ppr_pkg::CFG_DIM_W-1:0] cfg_data  = '0;

  residual_tracker tracker = new();

  int unsigned gap_odds    = 0;
  int unsigned stall_odds  = 0;
  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;

  predictive_pixel_residual_rle_size_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) tracker.write_register(cfg_index, cfg_data);
    if (rst_n && in_valid && !in_stall) tracker.note_pixel(in_data);
    if (rst_n && out_valid && !out_stall) tracker.check_output(out_data);
  end

  // receiver side: random stall bursts plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 12;
    endcase
  endfunction

  function automatic logic [7:0] pick_channel(logic [7:0] base);
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom);
      default: return base;
    endcase
  endfunction

  // noise, sparse noise on a flat color, nearly flat, and saturated mixes
  function automatic ppr_pkg::pix_t make_pixel(int style, ppr_pkg::pix_t base);
    ppr_pkg::pix_t px;
    case (style)
      0: px = 24'($urandom);
      1: px = ($urandom_range(0, 5) == 0) ? 24'($urandom) : base;
      2: px = ($urandom_range(0, 39) == 0) ? 24'($urandom) : base;
      default: begin
        px.red   = pick_channel(base.red);
        px.green = pick_channel(base.green);
        px.blue  = pick_channel(base.blue);
      end
    endcase
    return px;
  endfunction

  task automatic write_reg(logic [ppr_pkg::CFG_IDX_W-1:0] idx,
                           logic [ppr_pkg::CFG_DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(ppr_pkg::pix_t px);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.expected_res.size() != 0);
  endtask

  task automatic run_phase(logic [ppr_pkg::CFG_DIM_W-1:0] mode_word,
                           logic [ppr_pkg::CFG_DIM_W-1:0] w,
                           logic [ppr_pkg::CFG_DIM_W-1:0] h, int unsigned frames, int style);
    int unsigned   n, f, i;
    ppr_pkg::pix_t base;
    write_reg(ppr_pkg::CFG_MODE, mode_word);
    write_reg(ppr_pkg::CFG_WIDTH, w);
    write_reg(ppr_pkg::CFG_HEIGHT, h);
    n = residual_tracker::dim_limit(w, LINE_MAX) * residual_tracker::dim_limit(h, ROWS_MAX);
    for (f = 0; f < frames; f++) begin
      base = 24'($urandom);
      for (i = 0; i < n; i++) send_pixel(make_pixel(style, base));
    end
    end_phase();
  endtask

  initial begin
    logic [1:0]  modes [4];
    int unsigned m, random_start;
    modes = '{ppr_pkg::MODE_AVG, ppr_pkg::MODE_PLANAR, ppr_pkg::MODE_MED,
              ppr_pkg::MODE_AVG_ALT};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings give single-pixel frames that pass raw
    gap_odds = 4;
    stall_odds = 4;
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h808080);
    end_phase();

    write_reg(CFG_SPARE, 13'h1FFF);
    write_reg(ppr_pkg::CFG_MODE, {11'd0, ppr_pkg::MODE_AVG_ALT});
    write_reg(ppr_pkg::CFG_WIDTH, 13'd0);
    write_reg(ppr_pkg::CFG_HEIGHT, 13'd0);
    send_pixel(24'h7F80FF);
    send_pixel(24'h010203);
    end_phase();

    // 2x2 frames that saturate the residual both ways under every mode
    for (m = 0; m < 4; m++) begin
      write_reg(ppr_pkg::CFG_MODE, {11'd0, modes[m]});
      write_reg(ppr_pkg::CFG_WIDTH, 13'd2);
      write_reg(ppr_pkg::CFG_HEIGHT, 13'd2);
      send_pixel(24'h00FF5A);
      send_pixel(24'hFF00A5);
      send_pixel(24'hFF003C);
      send_pixel(24'h00FFC3);
      end_phase();
    end

    // wide rows with the output held off for a long stretch
    gap_odds = 0;
    stall_odds = 8;
    hold_req = 1'b1;
    run_phase({11'($urandom), ppr_pkg::MODE_MED}, 13'd64, 13'd2, 1, 1);

    gap_odds = 10;
    stall_odds = 10;
    run_phase({11'($urandom), ppr_pkg::MODE_PLANAR}, 13'd1, 13'd48, 1, 2);

    random_start = pixels_sent;
    while (pixels_sent < random_start + RANDOM_PIXELS) begin
      quiet = (pixels_sent >= random_start + RANDOM_PIXELS - QUIET_TAIL);
      gap_odds = pick_odds();
      stall_odds = pick_odds();
      run_phase({11'($urandom), 2'($urandom)}, 13'($urandom_range(1, 12)),
                13'($urandom_range(1, 6)), $urandom_range(1, 3), $urandom_range(0, 3));
    end

    quiet = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.close();
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ppr_pkg.sv
rtl/ppr_front.sv
rtl/ppr_queue.sv
rtl/ppr_back.sv
rtl/predictive_pixel_residual_rle_size_top.sv
tb/tb_predictive_pixel_residual_rle_size_top.sv
